// ===== rtl/core/brl_pkg.sv =====
`timescale 1ns / 1ps

package brl_pkg;

  localparam int COORD_WIDTH = 12;
  localparam int ERR_WIDTH   = COORD_WIDTH + 4;

  localparam logic [1:0] CMD_MOVE = 2'd0;
  localparam logic [1:0] CMD_LINE = 2'd1;
  localparam logic [1:0] CMD_NEXT = 2'd2;

  localparam logic [1:0] COLOR_STEEP_REV   = 2'd0;
  localparam logic [1:0] COLOR_STEEP       = 2'd1;
  localparam logic [1:0] COLOR_SHALLOW_REV = 2'd2;
  localparam logic [1:0] COLOR_SHALLOW     = 2'd3;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [COORD_WIDTH-1:0]        delta_t;
  typedef logic signed [ERR_WIDTH-1:0]   err_t;

  typedef struct packed {
    logic [1:0] command;
    coord_t     point_x;
    coord_t     point_y;
  } in_item_t;

  typedef struct packed {
    coord_t     pixel_x;
    coord_t     pixel_y;
    logic [1:0] color_code;
    logic       last_pixel;
  } out_item_t;

  typedef struct packed {
    coord_t     cursor_x;
    coord_t     cursor_y;
    coord_t     major_end;
    delta_t     delta_major;
    delta_t     delta_minor;
    err_t       error_term;
    logic       minor_negative;
    logic       steep_line;
    logic [1:0] line_color;
  } line_t;

  typedef struct packed {
    logic load;
    logic step;
  } walk_ctrl_t;

endpackage

// ===== rtl/core/bresenham_line_rasterizer.sv =====
`timescale 1ns / 1ps

// channel   ports                          transfer when
// input     in_valid in_ready in_data      in_valid && in_ready
// result    out_valid out_ready out_data   out_valid && out_ready
//
// one command per cycle while in_ready is high; a next command on an active line gives
// its pixel in the cycle after the input transfer, from the result register
// the pixel step is one add and compare on the line state registers
// in_ready drops only while the result register is full and not taken
// synchronous active-low reset clears pen, line activity and result valid

module bresenham_line_rasterizer import brl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  coord_t     pen_x_r;
  coord_t     pen_y_r;
  coord_t     pen_x_nxt;
  coord_t     pen_y_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  out_item_t  out_data_r;
  logic       in_xfer;
  logic       emit;
  walk_ctrl_t ctrl;
  line_t      setup_line;
  out_item_t  pixel;
  logic       active;

  assign in_ready = !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;
  assign emit     = in_xfer && (in_data.command == CMD_NEXT) && active;

  assign ctrl.load = in_xfer && (in_data.command == CMD_LINE);
  assign ctrl.step = emit;

  brl_setup u_setup (
    .start_x (pen_x_r),
    .start_y (pen_y_r),
    .end_x   (in_data.point_x),
    .end_y   (in_data.point_y),
    .line    (setup_line)
  );

  brl_walker u_walker (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .setup_line (setup_line),
    .pixel      (pixel),
    .active     (active)
  );

  always_comb begin
    pen_x_nxt = pen_x_r;
    pen_y_nxt = pen_y_r;
    if (in_xfer && (in_data.command inside {CMD_MOVE, CMD_LINE})) begin
      pen_x_nxt = in_data.point_x;
      pen_y_nxt = in_data.point_y;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_x_r     <= '0;
      pen_y_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pen_x_r     <= pen_x_nxt;
      pen_y_r     <= pen_y_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= pixel;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/core/brl_setup.sv =====
`timescale 1ns / 1ps

module brl_setup import brl_pkg::*; (
  input  coord_t start_x,
  input  coord_t start_y,
  input  coord_t end_x,
  input  coord_t end_y,
  output line_t  line
);

  logic signed [COORD_WIDTH:0] dx;
  logic signed [COORD_WIDTH:0] dy;
  logic [COORD_WIDTH:0]        adx;
  logic [COORD_WIDTH:0]        ady;
  logic [COORD_WIDTH:0]        amaj;
  logic [COORD_WIDTH:0]        amin;
  logic                        steep;
  logic                        swap;
  logic                        minor_sign;
  logic                        minor_zero;

  assign dx  = {end_x[COORD_WIDTH-1], end_x} - {start_x[COORD_WIDTH-1], start_x};
  assign dy  = {end_y[COORD_WIDTH-1], end_y} - {start_y[COORD_WIDTH-1], start_y};
  assign adx = dx[COORD_WIDTH] ? $unsigned(-dx) : $unsigned(dx);
  assign ady = dy[COORD_WIDTH] ? $unsigned(-dy) : $unsigned(dy);

  assign steep      = adx < ady;
  assign swap       = steep ? dy[COORD_WIDTH] : dx[COORD_WIDTH];
  assign amaj       = steep ? ady : adx;
  assign amin       = steep ? adx : ady;
  assign minor_sign = steep ? dx[COORD_WIDTH] : dy[COORD_WIDTH];
  assign minor_zero = (amin == '0);

  always_comb begin
    line.cursor_x       = swap ? end_x : start_x;
    line.cursor_y       = swap ? end_y : start_y;
    if (steep) begin
      line.major_end  = swap ? start_y : end_y;
      line.line_color = swap ? COLOR_STEEP_REV : COLOR_STEEP;
    end else begin
      line.major_end  = swap ? start_x : end_x;
      line.line_color = swap ? COLOR_SHALLOW_REV : COLOR_SHALLOW;
    end
    line.delta_major    = amaj[COORD_WIDTH-1:0];
    line.delta_minor    = amin[COORD_WIDTH-1:0];
    line.minor_negative = swap ? (!minor_sign && !minor_zero) : minor_sign;
    line.steep_line     = steep;
    line.error_term     = $signed({3'b000, amin[COORD_WIDTH-1:0], 1'b0})
                        - $signed({4'b0000, amaj[COORD_WIDTH-1:0]});
  end

endmodule

// ===== rtl/core/brl_walker.sv =====
`timescale 1ns / 1ps

module brl_walker import brl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  walk_ctrl_t ctrl,
  input  line_t      setup_line,
  output out_item_t  pixel,
  output logic       active
);

  line_t  line_r;
  line_t  line_nxt;
  logic   active_r;
  logic   active_nxt;
  logic   last;
  coord_t major_pos;
  coord_t minor_pos;
  coord_t minor_step;
  err_t   two_minor;
  err_t   two_major;

  assign major_pos  = line_r.steep_line ? line_r.cursor_y : line_r.cursor_x;
  assign minor_pos  = line_r.steep_line ? line_r.cursor_x : line_r.cursor_y;
  assign last       = major_pos >= line_r.major_end;
  assign minor_step = line_r.minor_negative ? minor_pos - coord_t'(1) : minor_pos + coord_t'(1);
  assign two_minor  = $signed({3'b000, line_r.delta_minor, 1'b0});
  assign two_major  = $signed({3'b000, line_r.delta_major, 1'b0});

  always_comb begin
    line_nxt   = line_r;
    active_nxt = active_r;
    if (ctrl.load) begin
      line_nxt   = setup_line;
      active_nxt = 1'b1;
    end else if (ctrl.step) begin
      if (last) begin
        active_nxt = 1'b0;
      end else begin
        if (line_r.error_term > 0) begin
          if (line_r.steep_line) begin
            line_nxt.cursor_x = minor_step;
          end else begin
            line_nxt.cursor_y = minor_step;
          end
          line_nxt.error_term = line_r.error_term + two_minor - two_major;
        end else begin
          line_nxt.error_term = line_r.error_term + two_minor;
        end
        if (line_r.steep_line) begin
          line_nxt.cursor_y = line_r.cursor_y + coord_t'(1);
        end else begin
          line_nxt.cursor_x = line_r.cursor_x + coord_t'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      line_r   <= '0;
    end else begin
      active_r <= active_nxt;
      line_r   <= line_nxt;
    end
  end

  assign pixel.pixel_x    = line_r.cursor_x;
  assign pixel.pixel_y    = line_r.cursor_y;
  assign pixel.color_code = line_r.line_color;
  assign pixel.last_pixel = last;
  assign active           = active_r;

endmodule

// ===== rtl/core/brl_checker.sv =====
`timescale 1ns / 1ps

module brl_checker import brl_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // empty result register never blocks input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // a result appears only after a next command transfer
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_data.command == CMD_NEXT))
    else $error("result without next command");

  // move or line commands give no result
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.command != CMD_NEXT && out_ready |=> !out_valid)
    else $error("result after non-next command");

endmodule

bind bresenham_line_rasterizer brl_checker u_brl_checker (.*);
